// ----- src/e2c_pkg.sv -----
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared types, constants and the month length table for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2c_pkg;

    localparam int unsigned IN_W   = 32;
    localparam int unsigned OUT_W  = 40;
    localparam int unsigned DAYS_W = 16;
    localparam int unsigned YEAR_W = 12;
    localparam int unsigned PROD_W = 29;

    // Reciprocals for division by 15 and by 3. The dividend is first shifted
    // right by two or three places, so the pair covers division by 60 and 24,
    // and the quotient is exact for any shifted dividend below 2^30.
    localparam logic [30:0] RECIP_15 = 31'd1145324613;  // ceil(2^34 / 15)
    localparam logic [30:0] RECIP_3  = 31'd1431655766;  // ceil(2^32 / 3)

    localparam logic [5:0] DIVISOR_60 = 6'd60;
    localparam logic [5:0] DIVISOR_24 = 6'd24;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [1:0]        EPOCH_Y4   = 2'd2;
    localparam logic [6:0]        EPOCH_Y100 = 7'd70;
    localparam logic [8:0]        EPOCH_Y400 = 9'd370;

    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] DAYS_COMMON = 9'd365;

    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_DIV_MIN,
        ST_DIV_HR,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    typedef enum logic {
        DIV_60,
        DIV_24
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_mul;
        div_sel_t div_sel;
        logic     cap_sec;
        logic     cap_min;
        logic     cap_hr;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                4'd11:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/e2c_datapath.sv -----
// ----------------------------------------------------------------------------
// e2c_datapath
// Reciprocal-multiply constant divider for seconds, minutes and hours, year
// and month stepping units and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_datapath (
    input  wire logic                          clk,
    input  wire logic [e2c_pkg::IN_W-1:0]      in_data,
    input  wire e2c_pkg::cmd_t                 cmd,
    output e2c_pkg::status_t                   status,
    output logic [e2c_pkg::OUT_W-1:0]          out_data
);

    logic [31:0]                    quot_reg, quot_next;
    logic [e2c_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [5:0]                     sec_reg, sec_next;
    logic [5:0]                     min_reg, min_next;
    logic [4:0]                     hr_reg, hr_next;
    logic [e2c_pkg::DAYS_W-1:0]     days_reg, days_next;
    logic [e2c_pkg::YEAR_W-1:0]     year_reg, year_next;
    logic [1:0]                     y4_reg, y4_next;
    logic [6:0]                     y100_reg, y100_next;
    logic [8:0]                     y400_reg, y400_next;
    logic [3:0]                     month_reg, month_next;
    logic [e2c_pkg::OUT_W-1:0]      out_reg, out_next;

    logic [29:0] mul_a;
    logic [30:0] mul_recip;
    logic [60:0] mul_full;
    logic [5:0]  divisor;
    logic [31:0] quot_val;
    logic [5:0]  rem_val;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;
    logic        year_done;
    logic        month_done;

    always_comb
    begin
        if (cmd.div_sel == e2c_pkg::DIV_24)
        begin
            divisor   = e2c_pkg::DIVISOR_24;
            mul_a     = {1'b0, quot_reg[31:3]};
            mul_recip = e2c_pkg::RECIP_3;
            quot_val  = {3'd0, prod_reg};
        end
        else
        begin
            divisor   = e2c_pkg::DIVISOR_60;
            mul_a     = quot_reg[31:2];
            mul_recip = e2c_pkg::RECIP_15;
            quot_val  = {5'd0, prod_reg[e2c_pkg::PROD_W-1:2]};
        end
        mul_full = {31'd0, mul_a} * {30'd0, mul_recip};

        // The remainder is below 64, so only the low six bits take part.
        rem_val = quot_reg[5:0] - 6'(quot_val[5:0] * divisor);

        leap     = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
        year_len = leap ? e2c_pkg::DAYS_LEAP : e2c_pkg::DAYS_COMMON;
        mon_len  = e2c_pkg::month_len(month_reg, leap);

        year_done  = (days_reg < {7'd0, year_len});
        month_done = (month_reg == e2c_pkg::MONTH_LAST) || (days_reg < {11'd0, mon_len});
    end

    assign status.year_done  = year_done;
    assign status.month_done = month_done;

    always_comb
    begin
        quot_next  = quot_reg;
        prod_next  = prod_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hr_next    = hr_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        y4_next    = y4_reg;
        y100_next  = y100_reg;
        y400_next  = y400_reg;
        month_next = month_reg;
        out_next   = out_reg;

        if (cmd.load)
        begin
            quot_next = in_data;
        end

        if (cmd.div_mul)
        begin
            prod_next = mul_full[60:32];
        end

        // Each quotient becomes the dividend of the next pass.
        if (cmd.cap_sec)
        begin
            sec_next  = rem_val;
            quot_next = quot_val;
        end
        if (cmd.cap_min)
        begin
            min_next  = rem_val;
            quot_next = quot_val;
        end
        if (cmd.cap_hr)
        begin
            hr_next    = rem_val[4:0];
            days_next  = quot_val[e2c_pkg::DAYS_W-1:0];
            year_next  = e2c_pkg::EPOCH_YEAR;
            y4_next    = e2c_pkg::EPOCH_Y4;
            y100_next  = e2c_pkg::EPOCH_Y100;
            y400_next  = e2c_pkg::EPOCH_Y400;
            month_next = 4'd0;
        end

        if (cmd.year_step && !year_done)
        begin
            days_next = days_reg - {7'd0, year_len};
            year_next = year_reg + 12'd1;
            y4_next   = y4_reg + 2'd1;
            y100_next = (y100_reg == 7'd99) ? 7'd0 : (y100_reg + 7'd1);
            y400_next = (y400_reg == 9'd399) ? 9'd0 : (y400_reg + 9'd1);
        end

        if (cmd.month_step && !month_done)
        begin
            days_next  = days_reg - {11'd0, mon_len};
            month_next = month_reg + 4'd1;
        end

        if (cmd.out_load)
        begin
            out_next = {2'd0, year_reg, month_reg + 4'd1,
                        days_reg[4:0] + 5'd1, hr_reg, min_reg, sec_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        prod_reg  <= prod_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hr_reg    <= hr_next;
        days_reg  <= days_next;
        year_reg  <= year_next;
        y4_reg    <= y4_next;
        y100_reg  <= y100_next;
        y400_reg  <= y400_next;
        month_reg <= month_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ----- src/e2c_ctrl.sv -----
// ----------------------------------------------------------------------------
// e2c_ctrl
// Sequencer for the conversion: three multiply-and-capture divider passes,
// year and month stepping, then hand-over to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire e2c_pkg::status_t  status,
    output e2c_pkg::cmd_t          cmd
);

    e2c_pkg::state_t             state_reg, state_next;
    logic                        phase_reg, phase_next;
    logic                        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= e2c_pkg::ST_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.div_sel = e2c_pkg::DIV_60;
        in_ready   = 1'b0;

        case (state_reg)
            e2c_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    state_next = e2c_pkg::ST_DIV_SEC;
                end
            end
            // Each pass multiplies in its first phase and captures in its second.
            e2c_pkg::ST_DIV_SEC:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                    cmd.div_mul = 1'b1;
                else
                begin
                    cmd.cap_sec = 1'b1;
                    state_next  = e2c_pkg::ST_DIV_MIN;
                end
            end
            e2c_pkg::ST_DIV_MIN:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                    cmd.div_mul = 1'b1;
                else
                begin
                    cmd.cap_min = 1'b1;
                    state_next  = e2c_pkg::ST_DIV_HR;
                end
            end
            e2c_pkg::ST_DIV_HR:
            begin
                cmd.div_sel = e2c_pkg::DIV_24;
                phase_next  = !phase_reg;
                if (!phase_reg)
                    cmd.div_mul = 1'b1;
                else
                begin
                    cmd.cap_hr = 1'b1;
                    state_next = e2c_pkg::ST_YEAR;
                end
            end
            e2c_pkg::ST_YEAR:
            begin
                cmd.year_step = 1'b1;
                if (status.year_done)
                    state_next = e2c_pkg::ST_MONTH;
            end
            e2c_pkg::ST_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (status.month_done)
                    state_next = e2c_pkg::ST_FINISH;
            end
            e2c_pkg::ST_FINISH:
            begin
                // Wait here until the previous result has left the register.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = e2c_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = e2c_pkg::ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == e2c_pkg::ST_DIV_SEC)
        else $error("accepted transaction did not start the divider");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded over an untaken result");

    a_load_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && state_reg == e2c_pkg::ST_IDLE)
        else $error("result not presented after load");

    a_phase_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (state_reg == e2c_pkg::ST_DIV_SEC ||
                       state_reg == e2c_pkg::ST_DIV_MIN ||
                       state_reg == e2c_pkg::ST_DIV_HR))
        else $error("divider phase set outside a divider pass");
`endif

endmodule

`default_nettype wire

// ----- src/epoch_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date and time of day.
// ----------------------------------------------------------------------------
//  Channel   Direction  Data                          Handshake
//  s_axis    in         epoch_seconds (32 bits)       s_tvalid / s_tready
//  m_axis    out        time and date fields (40 bits) m_tvalid / m_tready
//
//  A transaction is accepted, passes the three constant divisions, steps once
//  per elapsed year and per elapsed month plus a closing step for each loop,
//  and then loads the result.
//  Only one conversion is in flight; s_tready is high only while idle.
//  A result waiting on m_tready does not block the next input transaction;
//  the following result then waits in the sequencer. Reset clears the
//  sequencer and the output valid flag only.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [e2c_pkg::IN_W-1:0]     s_tdata,   // [31:0] epoch_seconds
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [21:17] day_of_month, [25:22] month_of_year, [37:26] calendar_year
    output logic [e2c_pkg::OUT_W-1:0]         m_tdata
);

    e2c_pkg::cmd_t    cmd;
    e2c_pkg::status_t status;

    e2c_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    e2c_datapath u_datapath (
        .clk      (clk),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sim/tb_epoch_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Self-checking bench for the epoch seconds to calendar converter. A queue of
// epoch values, directed corner times first and then random ones, feeds a
// driver on the slave stream. A monitor works out the expected date and time
// of every accepted transaction and checks the master stream against it in
// order. Both sides idle at random, and the receiver stalls for long
// stretches so that the converter backs up onto its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_epoch_seconds_to_calendar;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned LAST_DAY     = 49710;
    localparam int unsigned LONG_HOLD    = 500;
    localparam int unsigned TAIL_CYCLES  = 250;

    typedef struct packed {
        logic [31:0] epoch;
        logic        idle;
    } epoch_item_t;

    typedef struct packed {
        logic [31:0]                epoch;
        logic [5:0]                 second;
        logic [5:0]                 minute;
        logic [4:0]                 hour;
        logic [4:0]                 day;
        logic [3:0]                 month;
        logic [e2c_pkg::YEAR_W-1:0] year;
    } calendar_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [e2c_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [e2c_pkg::OUT_W-1:0]  m_tdata;

    epoch_item_t pending_epochs[$];
    calendar_t   expected_dates[$];

    int unsigned mon_len_tab [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned fail_count = 0;

    logic        in_fire  = 1'b0;
    logic        out_fire = 1'b0;
    int unsigned gap_left = 0;
    logic        cur_idle = 1'b1;

    int unsigned stall_left = 0;
    int unsigned quiet_left = 0;
    int unsigned hold_left  = 0;

    epoch_seconds_to_calendar dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic is_leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic calendar_t calendar_of(input logic [31:0] epoch);
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        calendar_t   c;
        t        = epoch;
        c.epoch  = epoch;
        c.second = 6'(t % 60);
        t        = t / 60;
        c.minute = 6'(t % 60);
        t        = t / 60;
        c.hour   = 5'(t % 24);
        days     = t / 24;
        yr       = e2c_pkg::EPOCH_YEAR;
        while (days >= (is_leap_year(yr) ? e2c_pkg::DAYS_LEAP : e2c_pkg::DAYS_COMMON))
        begin
            days = days - (is_leap_year(yr) ? e2c_pkg::DAYS_LEAP : e2c_pkg::DAYS_COMMON);
            yr++;
        end
        mon = 0;
        while (mon < 11)
        begin
            len = mon_len_tab[mon];
            if (mon == 1 && is_leap_year(yr))
                len++;
            if (days < len)
                break;
            days = days - len;
            mon++;
        end
        c.day   = 5'(days + 1);
        c.month = 4'(mon + 1);
        c.year  = yr[e2c_pkg::YEAR_W-1:0];
        return c;
    endfunction

    task automatic queue_epoch(input logic [31:0] epoch, input logic idle);
        epoch_item_t it;
        it.epoch = epoch;
        it.idle  = idle;
        pending_epochs.push_back(it);
        n_queued++;
    endtask

    // Returns once every queued epoch has been taken and answered.
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_dates.size() != 0)
            @(negedge clk);
    endtask

    // Sender: one transaction at a time, with a drawn gap after each one whose idle flag is set.
    always @(negedge clk)
    begin
        epoch_item_t nxt;
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (in_fire)
                gap_left = cur_idle ? $urandom_range(0, 3) : 0;
            if (gap_left == 0 && pending_epochs.size() != 0)
            begin
                nxt      = pending_epochs.pop_front();
                cur_idle = nxt.idle;
                s_tdata  <= nxt.epoch;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
        end
    end

    // Receiver: short random stalls, quiet stretches, and two long hold-offs.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if (quiet_left != 0)
                begin
                    quiet_left--;
                    stall_left = 0;
                end
                else
                begin
                    stall_left = $urandom_range(0, 3);
                    if ($urandom_range(0, 15) == 0)
                        quiet_left = 40;
                end
                if (n_results == 200 || n_results == 800)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on input transactions and checks output ones.
    always @(posedge clk)
    begin
        calendar_t want;
        calendar_t got;
        if (rst_n)
        begin
            in_fire  <= s_tvalid && s_tready;
            out_fire <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                n_results++;
                got.epoch  = '0;
                got.second = m_tdata[5:0];
                got.minute = m_tdata[11:6];
                got.hour   = m_tdata[16:12];
                got.day    = m_tdata[21:17];
                got.month  = m_tdata[25:22];
                got.year   = m_tdata[37:26];
                if (expected_dates.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year,
                                 got.month, got.day, got.hour, got.minute, got.second);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.second != want.second || got.minute != want.minute ||
                        got.hour != want.hour || got.day != want.day ||
                        got.month != want.month || got.year != want.year)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("mismatch for %0d: expected %0d-%0d-%0d %0d:%0d:%0d",
                                   want.epoch, want.year, want.month, want.day, want.hour,
                                   want.minute, want.second);
                            $display(", got %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                                     got.day, got.hour, got.minute, got.second);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_dates.push_back(calendar_of(s_tdata));
                n_accepted++;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned chunk;
        int unsigned k;
        int unsigned pick;
        logic [63:0] wide;
        logic [31:0] base;
        logic        idle_on;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Range ends, unit roll-overs, leap days and the century years.
        queue_epoch(32'd0, 1'b1);
        queue_epoch(32'd1, 1'b1);
        queue_epoch(32'd59, 1'b1);
        queue_epoch(32'd60, 1'b1);
        queue_epoch(32'd3599, 1'b1);
        queue_epoch(32'd3600, 1'b1);
        queue_epoch(32'd86399, 1'b1);
        queue_epoch(32'd86400, 1'b1);
        queue_epoch(32'd31535999, 1'b1);
        queue_epoch(32'd31536000, 1'b1);
        queue_epoch(32'd68169600, 1'b1);
        queue_epoch(32'd946684799, 1'b1);
        queue_epoch(32'd946684800, 1'b1);
        queue_epoch(32'd951782400, 1'b1);
        queue_epoch(32'd951868799, 1'b1);
        queue_epoch(32'd951868800, 1'b1);
        queue_epoch(32'd978307199, 1'b1);
        queue_epoch(32'd4102444800, 1'b0);
        queue_epoch(32'd4107542399, 1'b0);
        queue_epoch(32'd4107542400, 1'b0);
        queue_epoch(32'h7FFF_FFFF, 1'b0);
        queue_epoch(32'h8000_0000, 1'b0);
        queue_epoch(32'h5555_5555, 1'b1);
        queue_epoch(32'hAAAA_AAAA, 1'b1);
        queue_epoch(32'hFFFF_FFFE, 1'b1);
        queue_epoch(32'hFFFF_FFFF, 1'b1);
        wait_drained();

        for (chunk = 0; chunk < 13; chunk++)
        begin
            idle_on = (chunk % 4) != 3;
            for (k = 0; k < 100; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    wide = {32'd0, $urandom()};
                end
                else if (pick < 8)
                begin
                    // Just either side of a midnight, so that days, months and
                    // years roll over.
                    wide = 64'($urandom_range(0, LAST_DAY)) * DAY_SECS;
                    if ($urandom_range(0, 1) == 0)
                        wide = wide + $urandom_range(0, 2);
                    else
                        wide = wide + $urandom_range(DAY_SECS - 3, DAY_SECS - 1);
                end
                else if (pick == 8)
                begin
                    wide = {32'd0, 32'hFFFF_FFFF - $urandom_range(0, DAY_SECS * 40)};
                end
                else
                begin
                    // Sixty days either side of the end of February in 2000 or 2100.
                    base = ($urandom_range(0, 1) == 0) ? 32'd951782400 : 32'd4107542400;
                    wide = {32'd0, base} - 64'(DAY_SECS * 60)
                           + $urandom_range(0, DAY_SECS * 120);
                end
                if (wide > 64'hFFFF_FFFF)
                    wide = {32'd0, $urandom()};
                queue_epoch(wide[31:0], idle_on);
            end
            if (chunk == 6)
                wait_drained();
        end
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_dates.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
